@@ hdl/bit_field_and_varint_packer_defines.svh @@
// Assertion macros used by the packer's result buffer.
`ifndef BIT_FIELD_AND_VARINT_PACKER_DEFINES_SVH
`define BIT_FIELD_AND_VARINT_PACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFVP_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BFVP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bfvp_pkg.sv @@
// Types and constants shared by the bit packer modules.
package bfvp_pkg;

	localparam int BUDGET_W   = 24;
	localparam int BITS_OUT_W = 24;
	localparam int MAX_BYTES  = 6;

	localparam logic [1:0] OP_RAW  = 2'd0;
	localparam logic [1:0] OP_SVAR = 2'd1;
	localparam logic [1:0] OP_UVAR = 2'd2;
	localparam logic [1:0] OP_FIN  = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] value;
		logic [5:0]  bit_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0]            out_byte;
		logic                  byte_valid;
		logic                  last;
		logic                  error;
		logic [BITS_OUT_W-1:0] bits_written;
	} out_item_t;

	typedef enum logic [2:0] {
		BU_NOP,
		BU_CHECK,
		BU_PUT,
		BU_PUT_CHK,
		BU_FLUSH
	} bu_op_t;

	typedef struct packed {
		bu_op_t     op;
		logic       bit_val;
		logic [5:0] amt;
	} bu_cmd_t;

	typedef struct packed {
		logic       pass;
		logic       push;
		logic [7:0] data;
	} bu_stat_t;

endpackage

@@ hdl/bfvp_bit_unit.sv @@
// Shared bit writer: budget check, bit insert, position and sticky error.
module bfvp_bit_unit #(
	parameter int POSITION_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bfvp_pkg::bu_cmd_t              cmd,
	input  logic [bfvp_pkg::BUDGET_W-1:0]  bit_budget,
	input  logic                           allow_expand,
	output logic [POSITION_BITS-1:0]       position,
	output logic                           overflow,
	output bfvp_pkg::bu_stat_t             stat
);
	import bfvp_pkg::*;

	localparam int CW = ((POSITION_BITS > BUDGET_W) ? POSITION_BITS : BUDGET_W) + 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [POSITION_BITS-1:0] pos_q;
	logic [7:0]               part_q;
	logic                     ovf_q;
	logic [CW-1:0]            sum;
	logic                     fail;
	logic                     do_put;
	logic                     wr;
	logic [2:0]               low;

	always_comb begin
		sum    = CW'(pos_q) + CW'(cmd.amt);
		fail   = !allow_expand && (sum > CW'(bit_budget));
		low    = pos_q[2:0];
		do_put = (cmd.op == BU_PUT) || ((cmd.op == BU_PUT_CHK) && !fail);
		wr     = do_put && (pos_q != POS_MAX);
		stat.pass = !fail;
		stat.push = (wr && (low == 3'd7)) || ((cmd.op == BU_FLUSH) && (low != 3'd0));
		stat.data = (cmd.op == BU_FLUSH) ? part_q : {cmd.bit_val, part_q[6:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			part_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			case (cmd.op)
				BU_CHECK, BU_PUT_CHK: begin
					if (fail) begin
						ovf_q <= 1'b1;
					end
				end
				BU_FLUSH: begin
					pos_q  <= '0;
					part_q <= '0;
					ovf_q  <= 1'b0;
				end
				default: ;
			endcase
			if (wr) begin
				pos_q <= pos_q + 1'b1;
				if (low == 3'd7) begin
					part_q <= '0;
				end else begin
					part_q[low] <= cmd.bit_val;
				end
			end
		end
	end

	assign position = pos_q;
	assign overflow = ovf_q;

endmodule

@@ hdl/bfvp_res_buf.sv @@
// Byte store for one item and the result sequencer on the output channel.
`include "bit_field_and_varint_packer_defines.svh"
module bfvp_res_buf #(
	parameter int POSITION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bfvp_pkg::bu_stat_t       stat,
	input  logic                     start,
	input  logic                     overflow,
	input  logic [POSITION_BITS-1:0] position,
	output logic                     busy,
	output logic                     out_valid,
	input  logic                     out_stall,
	output bfvp_pkg::out_item_t      out_data
);
	import bfvp_pkg::*;

	localparam int IDX_W = $clog2(MAX_BYTES);
	localparam int CNT_W = $clog2(MAX_BYTES + 1);

	logic [7:0]       mem_q [MAX_BYTES];
	logic [7:0]       rd_data_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] rd_nxt;
	logic             busy_q;
	logic             push;
	logic             last;
	logic             take;

	assign push   = stat.push && (cnt_q < CNT_W'(MAX_BYTES));
	assign rd_nxt = rd_q + 1'b1;
	assign last   = (cnt_q == '0) || (CNT_W'(rd_q) + 1'b1 == cnt_q);
	assign take   = busy_q && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[cnt_q[IDX_W-1:0]] <= stat.data;
		end
		if (start) begin
			rd_data_q <= mem_q[0];
		end else if (take && !last) begin
			rd_data_q <= mem_q[rd_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rd_q   <= '0;
		end else begin
			if (push) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (start) begin
				busy_q <= 1'b1;
				rd_q   <= '0;
			end else if (take) begin
				if (last) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					rd_q <= rd_nxt;
				end
			end
		end
	end

	// empty store gives a single status transaction
	always_comb begin
		out_data.out_byte     = (cnt_q == '0) ? 8'd0 : rd_data_q;
		out_data.byte_valid   = (cnt_q != '0);
		out_data.last         = last;
		out_data.error        = overflow;
		out_data.bits_written = BITS_OUT_W'(position);
	end

	assign out_valid = busy_q;
	assign busy      = busy_q;

	`BFVP_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_W'(MAX_BYTES), "byte count past store depth")
	`BFVP_ASSERT_IMPL(a_no_push_busy, stat.push, !busy_q, "byte pushed while draining")
	`BFVP_ASSERT_IMPL(a_no_start_busy, start, !busy_q, "start while draining")
	`BFVP_ASSERT_NEXT(a_drain_done, take && last, !busy_q && (cnt_q == '0), "store not released")

endmodule

@@ hdl/bit_field_and_varint_packer.sv @@
// Bit packer top level: item sequencer, config registers and submodule wiring.
//
// Packs raw fields and nibble varints LSB-first into a byte stream. One item is
// handled at a time, bit by bit, through a single shared bit writer. A raw field
// is accepted, budget checked, written bit by bit and handed off; one that fails
// the budget skips the bits, and a zero-width one goes from accept to hand-off.
// A varint is accepted, writes or drops each code bit in turn and is handed off
// (code bits: sign for the signed kind, a mark and four bits per nibble up to the
// highest nonzero one, stop; at most 42). A finish is accept, flush and hand-off.
// An item's bytes are then drained one transaction per cycle (1 to 6) while the
// output side does not stall; only after a return to idle is another item taken.
// Every transaction of an item carries the error flag and bit position as they
// stand after the whole item. bit_budget sits at byte address 0, allow_expand at
// byte address 4; write them only while the block is idle.
module bit_field_and_varint_packer #(
	parameter int POSITION_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bfvp_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bfvp_pkg::out_item_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import bfvp_pkg::*;

	localparam logic REG_BIT_BUDGET   = 1'b0;
	localparam logic REG_ALLOW_EXPAND = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RAW_CHK,
		S_RAW,
		S_SIGN,
		S_VMARK,
		S_VNIB,
		S_FIN,
		S_EMIT,
		S_WAIT
	} state_t;

	state_t               state_q;
	logic [31:0]          value_q;
	logic [5:0]           cnt_q;
	logic [1:0]           nib_q;
	logic [BUDGET_W-1:0]  budget_q;
	logic                 expand_q;
	logic [5:0]           raw_cnt;
	bu_cmd_t              cmd;
	bu_stat_t             stat;
	logic [POSITION_BITS-1:0] position;
	logic                 overflow;
	logic                 busy;
	logic                 start;
	logic                 cfg_wr;

	// config port, zero wait state
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '1;
			expand_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_BIT_BUDGET:   budget_q <= pwdata[BUDGET_W-1:0];
				REG_ALLOW_EXPAND: expand_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_ALLOW_EXPAND) ? {31'd0, expand_q}
	                                               : {{(32 - BUDGET_W){1'b0}}, budget_q};

	// bit counts above 32 clamp to 32
	assign raw_cnt  = in_data.bit_count[5] ? 6'd32 : in_data.bit_count;
	assign in_stall = (state_q != S_IDLE);
	assign start    = (state_q == S_EMIT);

	// sequencer: one bit per cycle into the shared writer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.opcode)
							OP_RAW:  state_q <= (raw_cnt == '0) ? S_EMIT : S_RAW_CHK;
							OP_SVAR: state_q <= S_SIGN;
							OP_UVAR: state_q <= S_VMARK;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_RAW_CHK: state_q <= stat.pass ? S_RAW : S_EMIT;
				S_RAW: begin
					if (cnt_q == 6'd1) begin
						state_q <= S_EMIT;
					end
				end
				S_SIGN:  state_q <= S_VMARK;
				S_VMARK: state_q <= (value_q == '0) ? S_EMIT : S_VNIB;
				S_VNIB: begin
					if (nib_q == 2'd3) begin
						state_q <= S_VMARK;
					end
				end
				S_FIN:  state_q <= S_EMIT;
				S_EMIT: state_q <= S_WAIT;
				S_WAIT: begin
					if (!busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working value and counters
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				value_q <= in_data.value;
				cnt_q   <= raw_cnt;
			end
			S_RAW: begin
				value_q <= value_q >> 1;
				cnt_q   <= cnt_q - 1'b1;
			end
			S_SIGN: begin
				if (value_q[31]) begin
					value_q <= ~value_q;
				end
			end
			S_VMARK: nib_q <= '0;
			S_VNIB: begin
				value_q <= value_q >> 1;
				nib_q   <= nib_q + 1'b1;
			end
			default: ;
		endcase
	end

	// command to the bit writer
	always_comb begin
		cmd.op      = BU_NOP;
		cmd.bit_val = 1'b0;
		cmd.amt     = 6'd1;
		case (state_q)
			S_RAW_CHK: begin
				cmd.op  = BU_CHECK;
				cmd.amt = cnt_q;
			end
			S_RAW: begin
				cmd.op      = BU_PUT;
				cmd.bit_val = value_q[0];
			end
			S_SIGN: begin
				cmd.op      = BU_PUT_CHK;
				cmd.bit_val = value_q[31];
			end
			S_VMARK: begin
				// continuation mark, or the stop bit once the value is spent
				cmd.op      = BU_PUT_CHK;
				cmd.bit_val = (value_q != '0);
			end
			S_VNIB: begin
				cmd.op      = BU_PUT_CHK;
				cmd.bit_val = value_q[0];
			end
			S_FIN: cmd.op = BU_FLUSH;
			default: ;
		endcase
	end

	bfvp_bit_unit #(
		.POSITION_BITS (POSITION_BITS)
	) u_bit_unit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.bit_budget   (budget_q),
		.allow_expand (expand_q),
		.position     (position),
		.overflow     (overflow),
		.stat         (stat)
	);

	bfvp_res_buf #(
		.POSITION_BITS (POSITION_BITS)
	) u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.start     (start),
		.overflow  (overflow),
		.position  (position),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
